>>> hdl/crp_pkg.sv
// ----------------------------------------------------------------------------
// crp_pkg
// Shared constants, codes and types of the character raster plotter.
// ----------------------------------------------------------------------------
package crp_pkg;

  localparam int SCREEN_WIDTH  = 64;
  localparam int SCREEN_HEIGHT = 32;
  localparam int COL_W         = $clog2(SCREEN_WIDTH);
  localparam int ROW_W         = $clog2(SCREEN_HEIGHT);
  localparam int ADDR_W        = ROW_W + COL_W;
  localparam int CELL_DEPTH    = 1 << ADDR_W;
  localparam int CELL_W        = 3;

  localparam int COORD_W   = 32;
  localparam int SPAN_W    = COORD_W + 1;
  localparam int CW_W      = SPAN_W - COL_W;
  localparam int CH_W      = SPAN_W - ROW_W;
  localparam int DIV_D_W   = (CW_W > CH_W) ? CW_W : CH_W;
  localparam int DIV_N_W   = SPAN_W + 1;
  localparam int DIV_CNT_W = $clog2(DIV_N_W + 1);

  localparam int RD_ROW_W   = 5;
  localparam int RD_COL_W   = 6;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic [COORD_W-1:0] VIEW_LOW_RST  = COORD_W'(-655360);
  localparam logic [COORD_W-1:0] VIEW_HIGH_RST = COORD_W'(655360);

  typedef logic [CELL_W-1:0] cell_code_t;

  localparam cell_code_t CODE_BLANK = cell_code_t'(0);
  localparam cell_code_t CODE_VAXIS = cell_code_t'(1);
  localparam cell_code_t CODE_HAXIS = cell_code_t'(2);
  localparam cell_code_t CODE_CROSS = cell_code_t'(3);
  localparam cell_code_t CODE_POINT = cell_code_t'(4);

  typedef enum logic [1:0] {
    OP_CLEAR,
    OP_PLOT,
    OP_READ,
    OP_NOP
  } opcode_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_HORIZ_LOW,
    REG_HORIZ_HIGH,
    REG_VERT_LOW,
    REG_VERT_HIGH,
    REG_AXIS_EN
  } cfg_reg_t;

  typedef enum logic [3:0] {
    ST_SWEEP,
    ST_IDLE,
    ST_SIZE,
    ST_AXV_GO,
    ST_AXV_WAIT,
    ST_AXH_GO,
    ST_AXH_WAIT,
    ST_PLX_GO,
    ST_PLX_WAIT,
    ST_PLY_GO,
    ST_PLY_WAIT,
    ST_PLOT_WR,
    ST_READ,
    ST_RESP
  } crp_state_t;

  typedef struct packed {
    logic               start;
    logic [DIV_N_W-1:0] num;
    logic [DIV_D_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic               done;
    logic [DIV_N_W-1:0] quo;
  } div_rsp_t;

endpackage

>>> hdl/crp_in_if.sv
// ----------------------------------------------------------------------------
// crp_in_if
// Input item channel: opcode, point coordinates and cell to read.
// ----------------------------------------------------------------------------
interface crp_in_if;
  import crp_pkg::*;

  logic                       valid;
  logic                       ready;
  opcode_t                    opcode;
  logic signed [COORD_W-1:0]  point_x;
  logic signed [COORD_W-1:0]  point_y;
  logic        [RD_ROW_W-1:0] read_row;
  logic        [RD_COL_W-1:0] read_col;

  modport source (
    output valid, opcode, point_x, point_y, read_row, read_col,
    input  ready
  );

  modport sink (
    input  valid, opcode, point_x, point_y, read_row, read_col,
    output ready
  );
endinterface

>>> hdl/crp_out_if.sv
// ----------------------------------------------------------------------------
// crp_out_if
// Result item channel: cell code, point visibility and scale status.
// ----------------------------------------------------------------------------
interface crp_out_if;
  import crp_pkg::*;

  logic       valid;
  logic       ready;
  cell_code_t cell_code;
  logic       point_visible;
  logic       scale_valid;

  modport source (
    output valid, cell_code, point_visible, scale_valid,
    input  ready
  );

  modport sink (
    input  valid, cell_code, point_visible, scale_valid,
    output ready
  );
endinterface

>>> hdl/char_raster_plotter_unit.sv
// ----------------------------------------------------------------------------
// char_raster_plotter_unit
// Character-cell plot raster with clear, plot and read operations.
//
//   channel   dir  payload                                      handshake
//   in_item   in   opcode, point_x, point_y, read_row, read_col  valid/ready
//   out_item  out  cell_code, point_visible, scale_valid         valid/ready
//   cfg_*     in   cfg_index, cfg_wdata                          cfg_we
//
// One item at a time. Read: a registered fetch from the raster store. Plot:
// two passes of the shared divider when the scale is valid. Clear: up to two
// divider passes for the axes plus a sweep over all cells, one cell per cycle.
// After reset the same sweep blanks the raster, no item taken. A result waits
// in the output register; a stalled output holds the sequencer only when the
// next result is ready.
// ----------------------------------------------------------------------------
module char_raster_plotter_unit (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_we,
  input  logic [crp_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [crp_pkg::CFG_DATA_W-1:0]     cfg_wdata,
  crp_in_if.sink                             in_item,
  crp_out_if.source                          out_item
);
  import crp_pkg::*;

  crp_state_t state_r, state_nxt;

  logic [COORD_W-1:0] hlow_r, hhigh_r, vlow_r, vhigh_r;
  logic               axis_en_r;
  logic [CW_W-1:0]    cw_r;
  logic [CH_W-1:0]    ch_r;

  opcode_t             op_r;
  logic [COORD_W-1:0]  px_r, py_r;
  logic [RD_ROW_W-1:0] rrow_r;
  logic [RD_COL_W-1:0] rcol_r;

  logic             vax_ok_r, hax_ok_r;
  logic [COL_W-1:0] vax_col_r;
  logic [ROW_W-1:0] hax_row_r;
  logic             col_ok_r;
  logic [COL_W-1:0] col_r;
  logic [ROW_W-1:0] row_r;
  logic             div_neg_r, div_neg;

  logic [ROW_W-1:0] sweep_row_r;
  logic [COL_W-1:0] sweep_col_r;
  logic             sweep_resp_r;
  logic             sweep_last;
  cell_code_t       sweep_code;

  cell_code_t cell_mem_r [CELL_DEPTH];
  cell_code_t rd_data_r;
  logic       mem_we;
  logic [ADDR_W-1:0] mem_waddr;
  cell_code_t mem_wdata;
  logic [ADDR_W-1:0] rd_addr;
  logic       rd_ok;

  logic       vis_r;
  logic       out_valid_r, out_valid_nxt;
  cell_code_t out_code_r;
  logic       out_vis_r, out_scale_r;
  logic       out_load;
  logic       in_fire;

  div_req_t div_req;
  div_rsp_t div_rsp;

  logic [SPAN_W-1:0]  span_h, span_v, span_h_adj, span_v_adj;
  logic [DIV_D_W:0]   cw_ext, ch_ext;
  logic [DIV_D_W-1:0] cw_mag, ch_mag;
  logic [SPAN_W-1:0]  hneg, vneg, nx, ny, nx_mag, ny_mag;
  logic               scale_ok, axv_go, axh_go;
  logic               q_col_ok, q_row_ok;

  function automatic logic q_in_range(input logic [DIV_N_W-1:0] quo, input logic neg,
                                      input int limit);
    q_in_range = (quo < DIV_N_W'(limit)) && (!neg || (quo == '0));
  endfunction

  crp_divider u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  // operand preparation
  always_comb begin
    span_h     = {hhigh_r[COORD_W-1], hhigh_r} - {hlow_r[COORD_W-1], hlow_r};
    span_v     = {vhigh_r[COORD_W-1], vhigh_r} - {vlow_r[COORD_W-1], vlow_r};
    span_h_adj = span_h + (span_h[SPAN_W-1] ? SPAN_W'(SCREEN_WIDTH - 1) : '0);
    span_v_adj = span_v + (span_v[SPAN_W-1] ? SPAN_W'(SCREEN_HEIGHT - 1) : '0);
    cw_ext     = {{(DIV_D_W - CW_W + 1){cw_r[CW_W-1]}}, cw_r};
    ch_ext     = {{(DIV_D_W - CH_W + 1){ch_r[CH_W-1]}}, ch_r};
    cw_mag     = cw_r[CW_W-1] ? DIV_D_W'(-cw_ext) : DIV_D_W'(cw_ext);
    ch_mag     = ch_r[CH_W-1] ? DIV_D_W'(-ch_ext) : DIV_D_W'(ch_ext);
    hneg       = -{hlow_r[COORD_W-1], hlow_r};
    vneg       = -{vlow_r[COORD_W-1], vlow_r};
    nx         = {px_r[COORD_W-1], px_r} - {hlow_r[COORD_W-1], hlow_r};
    ny         = {py_r[COORD_W-1], py_r} - {vlow_r[COORD_W-1], vlow_r};
    nx_mag     = nx[SPAN_W-1] ? -nx : nx;
    ny_mag     = ny[SPAN_W-1] ? -ny : ny;
    scale_ok   = (cw_r != '0) && (ch_r != '0);
    axv_go     = axis_en_r && scale_ok && (hlow_r[COORD_W-1] || (hlow_r == '0)) &&
                 !hhigh_r[COORD_W-1];
    axh_go     = axis_en_r && scale_ok && (vlow_r[COORD_W-1] || (vlow_r == '0)) &&
                 !vhigh_r[COORD_W-1];
    q_col_ok   = q_in_range(div_rsp.quo, div_neg_r, SCREEN_WIDTH);
    q_row_ok   = q_in_range(div_rsp.quo, div_neg_r, SCREEN_HEIGHT);
  end

  always_comb begin
    sweep_last = (sweep_row_r == ROW_W'(SCREEN_HEIGHT - 1)) &&
                 (sweep_col_r == COL_W'(SCREEN_WIDTH - 1));
    if (hax_ok_r && (sweep_row_r == hax_row_r)) begin
      sweep_code = (vax_ok_r && (sweep_col_r == vax_col_r)) ? CODE_CROSS : CODE_HAXIS;
    end else begin
      sweep_code = (vax_ok_r && (sweep_col_r == vax_col_r)) ? CODE_VAXIS : CODE_BLANK;
    end
  end

  assign in_fire = in_item.valid && in_item.ready;
  assign rd_addr = {ROW_W'(rrow_r), COL_W'(rcol_r)};
  assign rd_ok   = (int'(rrow_r) < SCREEN_HEIGHT) && (int'(rcol_r) < SCREEN_WIDTH);

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_SWEEP: begin
        if (sweep_last) begin
          state_nxt = sweep_resp_r ? ST_RESP : ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_fire) begin
          case (in_item.opcode)
            OP_CLEAR: state_nxt = ST_SIZE;
            OP_PLOT:  state_nxt = ST_PLX_GO;
            OP_READ:  state_nxt = ST_READ;
            default:  state_nxt = ST_RESP;
          endcase
        end
      end
      ST_SIZE:     state_nxt = ST_AXV_GO;
      ST_AXV_GO:   state_nxt = axv_go ? ST_AXV_WAIT : ST_AXH_GO;
      ST_AXV_WAIT: if (div_rsp.done) state_nxt = ST_AXH_GO;
      ST_AXH_GO:   state_nxt = axh_go ? ST_AXH_WAIT : ST_SWEEP;
      ST_AXH_WAIT: if (div_rsp.done) state_nxt = ST_SWEEP;
      ST_PLX_GO:   state_nxt = scale_ok ? ST_PLX_WAIT : ST_RESP;
      ST_PLX_WAIT: if (div_rsp.done) state_nxt = ST_PLY_GO;
      ST_PLY_GO:   state_nxt = ST_PLY_WAIT;
      ST_PLY_WAIT: begin
        if (div_rsp.done) begin
          state_nxt = (col_ok_r && q_row_ok) ? ST_PLOT_WR : ST_RESP;
        end
      end
      ST_PLOT_WR:  state_nxt = ST_RESP;
      ST_READ:     state_nxt = ST_RESP;
      ST_RESP:     if (out_load) state_nxt = ST_IDLE;
      default:     state_nxt = ST_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    in_item.ready = 1'b0;
    div_req       = '0;
    div_neg       = 1'b0;
    mem_we        = 1'b0;
    mem_waddr     = '0;
    mem_wdata     = CODE_BLANK;
    out_load      = 1'b0;
    case (state_r)
      ST_IDLE: in_item.ready = 1'b1;
      ST_SWEEP: begin
        mem_we    = 1'b1;
        mem_waddr = {sweep_row_r, sweep_col_r};
        mem_wdata = sweep_code;
      end
      ST_AXV_GO: begin
        div_req.start = axv_go;
        div_req.num   = DIV_N_W'(hneg);
        div_req.den   = cw_mag;
        div_neg       = cw_r[CW_W-1];
      end
      ST_AXH_GO: begin
        div_req.start = axh_go;
        div_req.num   = DIV_N_W'(vneg);
        div_req.den   = ch_mag;
        div_neg       = ch_r[CH_W-1];
      end
      ST_PLX_GO: begin
        div_req.start = scale_ok;
        div_req.num   = {nx_mag, 1'b0} + DIV_N_W'(cw_mag);
        div_req.den   = DIV_D_W'({cw_mag, 1'b0});
        div_neg       = nx[SPAN_W-1] ^ cw_r[CW_W-1];
      end
      ST_PLY_GO: begin
        div_req.start = 1'b1;
        div_req.num   = {ny_mag, 1'b0} + DIV_N_W'(ch_mag);
        div_req.den   = DIV_D_W'({ch_mag, 1'b0});
        div_neg       = ny[SPAN_W-1] ^ ch_r[CH_W-1];
      end
      ST_PLOT_WR: begin
        mem_we    = 1'b1;
        mem_waddr = {row_r, col_r};
        mem_wdata = CODE_POINT;
      end
      ST_RESP: out_load = !out_valid_r || out_item.ready;
      default: ;
    endcase
  end

  assign out_valid_nxt = out_load || (out_valid_r && !out_item.ready);

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_SWEEP;
      out_valid_r  <= 1'b0;
      hlow_r       <= VIEW_LOW_RST;
      hhigh_r      <= VIEW_HIGH_RST;
      vlow_r       <= VIEW_LOW_RST;
      vhigh_r      <= VIEW_HIGH_RST;
      axis_en_r    <= 1'b1;
      cw_r         <= '0;
      ch_r         <= '0;
      vax_ok_r     <= 1'b0;
      hax_ok_r     <= 1'b0;
      sweep_row_r  <= '0;
      sweep_col_r  <= '0;
      sweep_resp_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        case (cfg_index)
          REG_HORIZ_LOW:  hlow_r    <= cfg_wdata[COORD_W-1:0];
          REG_HORIZ_HIGH: hhigh_r   <= cfg_wdata[COORD_W-1:0];
          REG_VERT_LOW:   vlow_r    <= cfg_wdata[COORD_W-1:0];
          REG_VERT_HIGH:  vhigh_r   <= cfg_wdata[COORD_W-1:0];
          REG_AXIS_EN:    axis_en_r <= cfg_wdata[0];
          default: ;
        endcase
      end
      case (state_r)
        ST_SWEEP: begin
          if (sweep_col_r == COL_W'(SCREEN_WIDTH - 1)) begin
            sweep_col_r <= '0;
            sweep_row_r <= sweep_last ? '0 : sweep_row_r + 1'b1;
          end else begin
            sweep_col_r <= sweep_col_r + 1'b1;
          end
        end
        ST_SIZE: begin
          cw_r         <= span_h_adj[SPAN_W-1:COL_W];
          ch_r         <= span_v_adj[SPAN_W-1:ROW_W];
          vax_ok_r     <= 1'b0;
          hax_ok_r     <= 1'b0;
          sweep_resp_r <= 1'b1;
        end
        ST_AXV_WAIT: if (div_rsp.done) vax_ok_r <= q_col_ok;
        ST_AXH_WAIT: if (div_rsp.done) hax_ok_r <= q_row_ok;
        default: ;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_fire) begin
      op_r   <= in_item.opcode;
      px_r   <= in_item.point_x;
      py_r   <= in_item.point_y;
      rrow_r <= in_item.read_row;
      rcol_r <= in_item.read_col;
      vis_r  <= 1'b0;
    end else if (state_r == ST_PLOT_WR) begin
      vis_r <= 1'b1;
    end
    if (div_req.start) begin
      div_neg_r <= div_neg;
    end
    if (div_rsp.done) begin
      case (state_r)
        ST_AXV_WAIT: vax_col_r <= COL_W'(div_rsp.quo);
        ST_AXH_WAIT: hax_row_r <= ROW_W'(SCREEN_HEIGHT - 1) - ROW_W'(div_rsp.quo);
        ST_PLX_WAIT: begin
          col_ok_r <= q_col_ok;
          col_r    <= COL_W'(div_rsp.quo);
        end
        ST_PLY_WAIT: row_r <= ROW_W'(SCREEN_HEIGHT - 1) - ROW_W'(div_rsp.quo);
        default: ;
      endcase
    end
    if (out_load) begin
      out_code_r  <= ((op_r == OP_READ) && rd_ok) ? rd_data_r : CODE_BLANK;
      out_vis_r   <= vis_r;
      out_scale_r <= scale_ok;
    end
  end

  // raster store
  always_ff @(posedge clk) begin
    if (mem_we) begin
      cell_mem_r[mem_waddr] <= mem_wdata;
    end
    rd_data_r <= cell_mem_r[rd_addr];
  end

  assign out_item.valid         = out_valid_r;
  assign out_item.cell_code     = out_code_r;
  assign out_item.point_visible = out_vis_r;
  assign out_item.scale_valid   = out_scale_r;

endmodule

>>> hdl/crp_divider.sv
// ----------------------------------------------------------------------------
// crp_divider
// Restoring unsigned divider, one quotient bit per cycle. Pulses done in the
// cycle after the last step; the quotient holds until the next start.
// ----------------------------------------------------------------------------
module crp_divider (
  input  logic              clk,
  input  logic              rst_n,
  input  crp_pkg::div_req_t req,
  output crp_pkg::div_rsp_t rsp
);
  import crp_pkg::*;

  logic [DIV_N_W-1:0]   quo_r, quo_nxt;
  logic [DIV_D_W-1:0]   rem_r, rem_nxt;
  logic [DIV_D_W-1:0]   den_r;
  logic [DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic                 busy_r, busy_nxt;
  logic                 done_r, done_nxt;
  logic [DIV_D_W:0]     trial;
  logic [DIV_D_W:0]     diff;

  always_comb begin
    trial    = {rem_r, quo_r[DIV_N_W-1]};
    diff     = trial - {1'b0, den_r};
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (req.start) begin
      quo_nxt  = req.num;
      rem_nxt  = '0;
      cnt_nxt  = DIV_CNT_W'(DIV_N_W);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (trial >= {1'b0, den_r}) begin
        rem_nxt = diff[DIV_D_W-1:0];
        quo_nxt = {quo_r[DIV_N_W-2:0], 1'b1};
      end else begin
        rem_nxt = trial[DIV_D_W-1:0];
        quo_nxt = {quo_r[DIV_N_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == DIV_CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    if (req.start) begin
      den_r <= req.den;
    end
  end

  assign rsp.done = done_r;
  assign rsp.quo  = quo_r;

endmodule

>>> tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for char_raster_plotter_unit. A directed table covers
// the reset state, extremes, every operation, zero scale and ignored index.
// Random phases then follow, each with a new view and axis setting: mostly
// a clear, then aimed and wild plots, reads and no-ops. Every result is
// checked against the table or an in-bench raster predictor. Both handshakes
// idle at random, with one long receiver hold-off and one idle-free stretch.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import crp_pkg::*;

  localparam int TOTAL_ITEMS   = 1350;
  localparam int IDLE_PCT      = 37;
  localparam int CALM_FROM     = 700;
  localparam int CALM_TO       = 900;
  localparam int HOLD_AT       = 300;
  localparam int HOLD_CYCLES   = 5000;
  localparam int SETTLE_CYCLES = 200;
  localparam int MAX_REPORTS   = 10;

  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = CFG_IDX_W'((1 << CFG_IDX_W) - 1);

  localparam logic [31:0] Q_POS10   = 32'h000A_0000;
  localparam logic [31:0] Q_NEG10   = 32'hFFF6_0000;
  localparam logic [31:0] Q_9P5     = 32'h0009_8000;
  localparam logic [31:0] Q_COL5P5  = 32'hFFF7_B800;
  localparam logic [31:0] Q_MAX     = 32'h7FFF_FFFF;
  localparam logic [31:0] Q_MIN     = 32'h8000_0000;

  typedef struct packed {
    opcode_t                   op;
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic [RD_ROW_W-1:0]       r;
    logic [RD_COL_W-1:0]       c;
  } raster_cmd_t;

  typedef struct packed {
    cell_code_t code;
    logic       vis;
    logic       scl;
  } raster_rsp_t;

  typedef struct {
    bit                    wr;
    logic [CFG_IDX_W-1:0]  idx;
    logic [31:0]           val;
    opcode_t               op;
    logic [31:0]           x;
    logic [31:0]           y;
    logic [RD_ROW_W-1:0]   r;
    logic [RD_COL_W-1:0]   c;
    bit                    chk;
    cell_code_t            code;
    bit                    vis;
    bit                    scl;
  } stim_row_t;

  // wr idx val op x y row col | chk code vis scale
  stim_row_t directed_steps [24] = '{
    '{0, '0, '0, OP_READ,  '0, '0, 0, 0,         1, CODE_BLANK, 0, 0},
    '{0, '0, '0, OP_PLOT,  '0, '0, 0, 0,         1, CODE_BLANK, 0, 0},
    '{0, '0, '0, OP_NOP,   '0, '0, 0, 0,         1, CODE_BLANK, 0, 0},
    '{0, '0, '0, OP_CLEAR, '0, '0, 0, 0,         1, CODE_BLANK, 0, 1},
    '{0, '0, '0, OP_READ,  '0, '0, 15, 32,       1, CODE_CROSS, 0, 1},
    '{0, '0, '0, OP_READ,  '0, '0, 0, 32,        1, CODE_VAXIS, 0, 1},
    '{0, '0, '0, OP_READ,  '0, '0, 15, 0,        1, CODE_HAXIS, 0, 1},
    '{0, '0, '0, OP_READ,  '0, '0, 31, 63,       1, CODE_BLANK, 0, 1},
    '{0, '0, '0, OP_PLOT,  '0, '0, 0, 0,         1, CODE_BLANK, 1, 1},
    '{0, '0, '0, OP_READ,  '0, '0, 15, 32,       1, CODE_POINT, 0, 1},
    '{0, '0, '0, OP_PLOT,  Q_MAX, Q_MIN, 0, 0,   1, CODE_BLANK, 0, 1},
    '{0, '0, '0, OP_PLOT,  Q_MIN, Q_MAX, 31, 63, 1, CODE_BLANK, 0, 1},
    '{0, '0, '0, OP_PLOT,  Q_NEG10, Q_9P5, 0, 0, 0, CODE_BLANK, 0, 0},
    '{0, '0, '0, OP_READ,  '0, '0, 0, 0,         0, CODE_BLANK, 0, 0},
    '{0, '0, '0, OP_PLOT,  Q_COL5P5, '0, 0, 0,   0, CODE_BLANK, 0, 0},
    '{0, '0, '0, OP_READ,  '0, '0, 15, 6,        0, CODE_BLANK, 0, 0},
    '{1, REG_AXIS_EN, '0, OP_NOP, '0, '0, 0, 0,  0, CODE_BLANK, 0, 0},
    '{0, '0, '0, OP_CLEAR, '0, '0, 0, 0,         1, CODE_BLANK, 0, 1},
    '{0, '0, '0, OP_READ,  '0, '0, 15, 32,       1, CODE_BLANK, 0, 1},
    '{1, REG_UNUSED, 32'd1, OP_NOP, '0, '0, 0, 0, 0, CODE_BLANK, 0, 0},
    '{1, REG_HORIZ_HIGH, Q_NEG10, OP_NOP, '0, '0, 0, 0, 0, CODE_BLANK, 0, 0},
    '{0, '0, '0, OP_CLEAR, '0, '0, 0, 0,         1, CODE_BLANK, 0, 0},
    '{0, '0, '0, OP_PLOT,  '0, '0, 0, 0,         1, CODE_BLANK, 0, 0},
    '{0, '0, '0, OP_READ,  '0, '0, 15, 32,       1, CODE_BLANK, 0, 0}
  };

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  crp_in_if  in_ch ();
  crp_out_if out_ch ();

  char_raster_plotter_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_item   (in_ch),
    .out_item  (out_ch)
  );

  // predictor state
  cell_code_t screen [SCREEN_HEIGHT][SCREEN_WIDTH];
  longint     h_lo, h_hi, v_lo, v_hi;
  bit         axis_on;
  longint     cell_w, cell_h;
  int         last_row, last_col, ax_row, ax_col;

  raster_rsp_t pending_rsp [$];
  int items_sent;
  int errors;
  int n_clear, n_plot, n_marked, n_read, n_nop, n_views;
  int hold_left;
  bit hold_done;

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  function automatic bit no_idle();
    return items_sent >= CALM_FROM && items_sent < CALM_TO;
  endfunction

  function automatic longint round_div(longint n, longint d);
    longint an, ad, q;
    an = (n < 0) ? -n : n;
    ad = (d < 0) ? -d : d;
    q = (2 * an + ad) / (2 * ad);
    return ((n < 0) != (d < 0)) ? -q : q;
  endfunction

  function automatic raster_rsp_t apply_cmd(raster_cmd_t cmd);
    raster_rsp_t rsp;
    longint col, row;
    bit vdrawn;
    rsp = '0;
    vdrawn = 1'b0;
    col = 0;
    case (cmd.op)
      OP_CLEAR: begin
        n_clear++;
        cell_w = (h_hi - h_lo) / SCREEN_WIDTH;
        cell_h = (v_hi - v_lo) / SCREEN_HEIGHT;
        foreach (screen[i, j]) screen[i][j] = CODE_BLANK;
        ax_row = -1;
        ax_col = -1;
        if (axis_on && cell_w != 0 && cell_h != 0) begin
          if (h_lo <= 0 && h_hi >= 0) begin
            col = -h_lo / cell_w;
            if (col < SCREEN_WIDTH) begin
              vdrawn = 1'b1;
              ax_col = int'(col);
              for (int i = 0; i < SCREEN_HEIGHT; i++) screen[i][col] = CODE_VAXIS;
            end
          end
          if (v_lo <= 0 && v_hi >= 0) begin
            row = SCREEN_HEIGHT - 1 - (-v_lo / cell_h);
            if (row >= 0) begin
              ax_row = int'(row);
              for (int j = 0; j < SCREEN_WIDTH; j++) screen[row][j] = CODE_HAXIS;
              if (vdrawn) screen[row][col] = CODE_CROSS;
            end
          end
        end
      end
      OP_PLOT: begin
        n_plot++;
        if (cell_w != 0 && cell_h != 0) begin
          col = round_div(longint'(cmd.x) - h_lo, cell_w);
          row = SCREEN_HEIGHT - 1 - round_div(longint'(cmd.y) - v_lo, cell_h);
          if (col >= 0 && col < SCREEN_WIDTH && row >= 0 && row < SCREEN_HEIGHT) begin
            screen[row][col] = CODE_POINT;
            rsp.vis = 1'b1;
            last_row = int'(row);
            last_col = int'(col);
            n_marked++;
          end
        end
      end
      OP_READ: begin
        n_read++;
        rsp.code = screen[cmd.r][cmd.c];
      end
      default: n_nop++;
    endcase
    rsp.scl = (cell_w != 0 && cell_h != 0);
    return rsp;
  endfunction

  function automatic logic [31:0] aim_coord(longint base, longint step, int idx);
    longint a, j;
    a = ((step < 0) ? -step : step) / 2;
    case ($urandom_range(3))
      0: j = 0;
      1: j = a;
      2: j = -a;
      default: j = longint'($urandom_range(0, 32'(2 * a))) - a;
    endcase
    return 32'(base + idx * step + j);
  endfunction

  task automatic pick_view(output logic [31:0] lo, output logic [31:0] hi);
    longint a, b, t;
    case ($urandom_range(11))
      0: begin a = -655360; b = 655360; end
      1: begin a = longint'($signed(Q_MIN)); b = longint'($signed(Q_MAX)); end
      2: begin a = longint'($signed($urandom)); b = a; end
      3: begin
        a = longint'($signed($urandom));
        b = longint'($signed($urandom));
        if (a < b) begin t = a; a = b; b = t; end
      end
      4: begin
        a = longint'($urandom_range(0, 4_000_000)) - 2_000_000;
        b = a + $urandom_range(64, 8192);
      end
      5: begin
        a = $urandom_range(1, 1_000_000);
        b = a + $urandom_range(64, 10_000_000);
      end
      6: begin a = longint'($signed($urandom)); b = longint'($signed($urandom)); end
      7: begin
        a = longint'($urandom_range(0, 4_000_000)) - 2_000_000;
        b = a + $urandom_range(1, 63);
      end
      8: begin a = 0; b = $urandom_range(64, 32'h7FFF_FFFF); end
      9: begin a = -longint'($urandom_range(64, 32'h7FFF_FFFF)); b = 0; end
      default: begin
        a = -longint'($urandom_range(65536, 4_000_000));
        b = $urandom_range(65536, 4_000_000);
      end
    endcase
    lo = 32'(a);
    hi = 32'(b);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    case (idx)
      REG_HORIZ_LOW:  h_lo = longint'($signed(data));
      REG_HORIZ_HIGH: h_hi = longint'($signed(data));
      REG_VERT_LOW:   v_lo = longint'($signed(data));
      REG_VERT_HIGH:  v_hi = longint'($signed(data));
      REG_AXIS_EN:    axis_on = data[0];
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    while (pending_rsp.size() != 0) @(negedge clk);
  endtask

  task automatic send_item(raster_cmd_t cmd, bit typed, raster_rsp_t typed_rsp);
    int gap;
    raster_rsp_t rsp;
    gap = 0;
    if (!no_idle()) while ($urandom_range(99) < IDLE_PCT) gap++;
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid    <= 1'b1;
    in_ch.opcode   <= cmd.op;
    in_ch.point_x  <= cmd.x;
    in_ch.point_y  <= cmd.y;
    in_ch.read_row <= cmd.r;
    in_ch.read_col <= cmd.c;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    rsp = apply_cmd(cmd);
    if (typed) rsp = typed_rsp;
    pending_rsp.push_back(rsp);
    items_sent++;
    @(negedge clk);
  endtask

  // receiver: random stalls, one long hold-off
  always @(negedge clk) begin
    if (hold_left > 0) begin
      out_ch.ready <= 1'b0;
      hold_left--;
    end else if (!hold_done && items_sent >= HOLD_AT) begin
      hold_done = 1'b1;
      hold_left = HOLD_CYCLES - 1;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= no_idle() || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  always @(posedge clk) begin
    raster_rsp_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_rsp.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("%0t: unexpected result code %0d visible %0b scale %0b", $time,
                   out_ch.cell_code, out_ch.point_visible, out_ch.scale_valid);
      end else begin
        want = pending_rsp.pop_front();
        if (out_ch.cell_code !== want.code || out_ch.point_visible !== want.vis ||
            out_ch.scale_valid !== want.scl) begin
          errors++;
          if (errors <= MAX_REPORTS)
            $display("%0t: mismatch exp/act code %0d/%0d visible %0b/%0b scale %0b/%0b",
                     $time, want.code, out_ch.cell_code, want.vis, out_ch.point_visible,
                     want.scl, out_ch.scale_valid);
        end
      end
    end
  end

  initial begin
    #40ms;
    $display("Timed out with %0d results outstanding", pending_rsp.size());
    $display("** char_raster_plotter_unit: FAILED **");
    $finish;
  end

  initial begin
    stim_row_t   row;
    raster_cmd_t cmd;
    raster_rsp_t want;
    logic [31:0] lo, hi;
    int          phase_len, pick;

    rst_n          = 1'b0;
    cfg_we         = 1'b0;
    cfg_index      = '0;
    cfg_wdata      = '0;
    in_ch.valid    = 1'b0;
    in_ch.opcode   = OP_NOP;
    in_ch.point_x  = '0;
    in_ch.point_y  = '0;
    in_ch.read_row = '0;
    in_ch.read_col = '0;
    out_ch.ready   = 1'b0;

    h_lo = longint'($signed(VIEW_LOW_RST));
    h_hi = longint'($signed(VIEW_HIGH_RST));
    v_lo = longint'($signed(VIEW_LOW_RST));
    v_hi = longint'($signed(VIEW_HIGH_RST));
    axis_on = 1'b1;
    cell_w = 0;
    cell_h = 0;
    foreach (screen[i, j]) screen[i][j] = CODE_BLANK;
    last_row = -1;
    last_col = -1;
    ax_row = -1;
    ax_col = -1;

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (directed_steps[i]) begin
      row = directed_steps[i];
      if (row.wr) begin
        wait_drained();
        write_reg(row.idx, row.val);
      end else begin
        cmd.op = row.op;
        cmd.x  = row.x;
        cmd.y  = row.y;
        cmd.r  = row.r;
        cmd.c  = row.c;
        want.code = row.code;
        want.vis  = row.vis;
        want.scl  = row.scl;
        send_item(cmd, row.chk, want);
      end
    end

    while (items_sent < TOTAL_ITEMS) begin
      wait_drained();
      pick_view(lo, hi);
      write_reg(REG_HORIZ_LOW, lo);
      write_reg(REG_HORIZ_HIGH, hi);
      pick_view(lo, hi);
      write_reg(REG_VERT_LOW, lo);
      write_reg(REG_VERT_HIGH, hi);
      write_reg(REG_AXIS_EN, 32'($urandom_range(99) < 75));
      if ($urandom_range(9) < 3)
        write_reg(CFG_IDX_W'($urandom_range(REG_AXIS_EN + 1, REG_UNUSED)), $urandom);
      n_views++;

      phase_len = $urandom_range(30, 70);
      for (int k = 0; k < phase_len; k++) begin
        cmd.op = OP_READ;
        cmd.x  = $urandom;
        cmd.y  = $urandom;
        cmd.r  = RD_ROW_W'($urandom);
        cmd.c  = RD_COL_W'($urandom);
        pick = $urandom_range(99);
        if (k == 0 && $urandom_range(9) != 0) begin
          cmd.op = OP_CLEAR;
        end else if (pick < 3) begin
          cmd.op = OP_CLEAR;
        end else if (pick < 6) begin
          cmd.op = OP_NOP;
        end else if (pick < 55) begin
          cmd.op = OP_PLOT;
          if ($urandom_range(99) < 85) begin
            cmd.x = aim_coord(h_lo, cell_w, int'($urandom_range(0, 67)) - 2);
            cmd.y = aim_coord(v_lo, cell_h, int'($urandom_range(0, 35)) - 2);
          end
        end else begin
          case ($urandom_range(3))
            2: if (last_row >= 0) begin
              cmd.r = RD_ROW_W'(last_row);
              cmd.c = RD_COL_W'(last_col);
            end
            3: begin
              if (ax_row >= 0 && $urandom_range(1)) cmd.r = RD_ROW_W'(ax_row);
              if (ax_col >= 0 && $urandom_range(1)) cmd.c = RD_COL_W'(ax_col);
            end
            default: ;
          endcase
        end
        send_item(cmd, 1'b0, '0);
      end
    end

    wait_drained();
    repeat (SETTLE_CYCLES) @(negedge clk);
    $display("Covered %0d items over %0d view settings: %0d clears, %0d plots (%0d landed),",
             items_sent, n_views, n_clear, n_plot, n_marked);
    $display("%0d reads, %0d no-ops; %0d result mismatches", n_read, n_nop, errors);
    if (errors == 0) begin
      $display("** char_raster_plotter_unit: PASSED **");
    end else begin
      $display("** char_raster_plotter_unit: FAILED **");
    end
    $finish;
  end

endmodule

>>> char_raster_plotter_unit.f
hdl/crp_pkg.sv
hdl/crp_in_if.sv
hdl/crp_out_if.sv
hdl/crp_divider.sv
hdl/char_raster_plotter_unit.sv
tb/tb_top.sv
